@@ design/twc_pkg.sv @@
package twc_pkg;

   localparam int MAX_TAPS      = 128;
   localparam int MAX_DELAY     = 63;
   localparam int HISTORY_DEPTH = 256;
   localparam int MAX_TRACE     = 65536;

   localparam int TAP_W    = 16;
   localparam int SAMPLE_W = 24;
   localparam int CSR_W    = 8;
   localparam int COUNT_W  = 16;
   localparam int FRAC_W   = 15;

   localparam int TAP_AW  = $clog2(MAX_TAPS);
   localparam int HIST_AW = $clog2(HISTORY_DEPTH);
   localparam int POS_W   = COUNT_W + 2;
   localparam int PROD_W  = TAP_W + SAMPLE_W;
   localparam int ACC_W   = PROD_W + TAP_AW + 1;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic CSR_ZERO_SHIFT = 1'b0;
   localparam logic CSR_TAP_COUNT  = 1'b1;

   typedef struct packed {
      logic                       tap_wr_en;
      logic [TAP_AW-1:0]          tap_wr_addr;
      logic signed [TAP_W-1:0]    tap_wr_data;
      logic                       hist_wr_en;
      logic [HIST_AW-1:0]         hist_wr_addr;
      logic signed [SAMPLE_W-1:0] hist_wr_data;
      logic                       rd_en;
      logic [TAP_AW-1:0]          tap_rd_addr;
      logic [HIST_AW-1:0]         hist_rd_addr;
      logic                       acc_clear;
   } twc_ctrl_type;

endpackage

@@ design/twc_datapath.sv @@
module twc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  twc_pkg::twc_ctrl_type                  ctrl,
   output logic                                   busy,
   output logic signed [twc_pkg::SAMPLE_W-1:0]    result
);

   logic signed [twc_pkg::TAP_W-1:0]    tap_mem [twc_pkg::MAX_TAPS];
   logic signed [twc_pkg::SAMPLE_W-1:0] hist_mem [twc_pkg::HISTORY_DEPTH];

   logic signed [twc_pkg::TAP_W-1:0]    tap_q_ff;
   logic signed [twc_pkg::SAMPLE_W-1:0] hist_q_ff;
   logic                                rd_vld_ff;
   logic signed [twc_pkg::PROD_W-1:0]   prod_ff;
   logic                                mul_vld_ff;
   logic signed [twc_pkg::ACC_W-1:0]    acc_ff;
   logic signed [twc_pkg::ACC_W-1:0]    shifted;

   localparam logic signed [twc_pkg::ACC_W-1:0] SAT_HI =
      twc_pkg::ACC_W'((64'sd1 <<< (twc_pkg::SAMPLE_W - 1)) - 64'sd1);
   localparam logic signed [twc_pkg::ACC_W-1:0] SAT_LO =
      twc_pkg::ACC_W'(-(64'sd1 <<< (twc_pkg::SAMPLE_W - 1)));

   // tap and history memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (ctrl.tap_wr_en) begin
         tap_mem[ctrl.tap_wr_addr] <= ctrl.tap_wr_data;
      end
      if (ctrl.hist_wr_en) begin
         hist_mem[ctrl.hist_wr_addr] <= ctrl.hist_wr_data;
      end
      tap_q_ff  <= tap_mem[ctrl.tap_rd_addr];
      hist_q_ff <= hist_mem[ctrl.hist_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= ctrl.rd_en;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= tap_q_ff * hist_q_ff;
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_ff <= acc_ff + twc_pkg::ACC_W'(prod_ff);
      end
   end

   assign busy = rd_vld_ff | mul_vld_ff;

   // floor shift then saturate
   always_comb begin
      shifted = acc_ff >>> twc_pkg::FRAC_W;
      if (shifted > SAT_HI) begin
         result = twc_pkg::SAMPLE_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         result = twc_pkg::SAMPLE_W'(SAT_LO);
      end else begin
         result = twc_pkg::SAMPLE_W'(shifted);
      end
   end

endmodule

@@ design/trace_wavelet_convolver_core.sv @@
// channel   direction  handshake               payload
// req_      in         req_valid / req_ready   opcode, tap_index, tap_value, sample_value,
//                                              last_sample
// rsp_      out        rsp_valid / rsp_ready   out_sample, out_index, out_last
// csr_      in         csr_wr_en               csr_addr, csr_wdata
//
// a load transaction writes one tap; a sample transaction writes the history memory and
// produces its outputs before the next request is taken, up to 64 outputs on the last sample
// the cost of an output is set by the single multiply-accumulate stepping over the
// tap memory and the history memory, one tap per cycle
// synchronous reset clears control state; memories are not cleared
// a held result stalls the next output at its write into the output register
module trace_wavelet_convolver_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [twc_pkg::TAP_AW-1:0]          req_tap_index,
   input  logic signed [twc_pkg::TAP_W-1:0]    req_tap_value,
   input  logic signed [twc_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [twc_pkg::SAMPLE_W-1:0] rsp_out_sample,
   output logic [twc_pkg::COUNT_W-1:0]         rsp_out_index,
   output logic                                rsp_out_last,
   input  logic                                csr_wr_en,
   input  logic                                csr_addr,
   input  logic [twc_pkg::CSR_W-1:0]           csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   localparam int CW = twc_pkg::COUNT_W;
   localparam int PW = twc_pkg::POS_W;
   localparam int RW = twc_pkg::CSR_W;

   logic [2:0]                  state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               cur_ff, cur_in;
   logic [CW-1:0]               lo_ff, lo_in;
   logic [CW-1:0]               o_ff, o_in;
   logic [CW-1:0]               oend_ff, oend_in;
   logic                        last_ff, last_in;
   logic signed [RW-1:0]        z_ff, z_in;
   logic [RW-1:0]               l_ff, l_in;
   logic signed [PW-1:0]        j_ff, j_in;
   logic [twc_pkg::TAP_AW-1:0]  k_ff, k_in;
   logic [RW-1:0]               zero_shift_ff;
   logic [RW-1:0]               tap_count_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [twc_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CW-1:0]                   rsp_index_ff, rsp_index_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic signed [RW-1:0]        z_eff;
   logic [RW-1:0]               d_eff;
   logic [RW-1:0]               l_eff;
   logic                        reach;
   logic                        is_last;
   logic                        in_range;

   twc_pkg::twc_ctrl_type       ctrl;
   logic                        dp_busy;
   logic signed [twc_pkg::SAMPLE_W-1:0] dp_result;

   twc_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .busy   (dp_busy),
      .result (dp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_shift_ff <= '0;
         tap_count_ff  <= RW'(1);
      end else if (csr_wr_en) begin
         case (csr_addr)
            twc_pkg::CSR_ZERO_SHIFT: zero_shift_ff <= csr_wdata;
            twc_pkg::CSR_TAP_COUNT:  tap_count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if ($signed(zero_shift_ff) > $signed(RW'(twc_pkg::MAX_DELAY))) begin
         z_eff = RW'(twc_pkg::MAX_DELAY);
      end else begin
         z_eff = $signed(zero_shift_ff);
      end
      d_eff = z_eff[RW-1] ? '0 : z_eff;
      if (tap_count_ff == '0) begin
         l_eff = RW'(1);
      end else if (tap_count_ff > RW'(twc_pkg::MAX_TAPS)) begin
         l_eff = RW'(twc_pkg::MAX_TAPS);
      end else begin
         l_eff = tap_count_ff;
      end
      reach    = count_ff >= CW'(d_eff);
      is_last  = req_last_sample || (count_ff == CW'(twc_pkg::MAX_TRACE - 1));
      in_range = (j_ff >= $signed({2'b00, lo_ff})) && (j_ff <= $signed({2'b00, cur_ff}));
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      lo_in         = lo_ff;
      o_in          = o_ff;
      oend_in       = oend_ff;
      last_in       = last_ff;
      z_in          = z_ff;
      l_in          = l_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;

      ctrl              = '0;
      ctrl.tap_wr_addr  = req_tap_index;
      ctrl.tap_wr_data  = req_tap_value;
      ctrl.hist_wr_addr = count_ff[twc_pkg::HIST_AW-1:0];
      ctrl.hist_wr_data = req_sample_value;
      ctrl.tap_rd_addr  = k_ff;
      ctrl.hist_rd_addr = j_ff[twc_pkg::HIST_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == twc_pkg::OP_LOAD) begin
                  ctrl.tap_wr_en = 1'b1;
               end else begin
                  ctrl.hist_wr_en = 1'b1;
                  cur_in = count_ff;
                  lo_in  = (count_ff >= CW'(twc_pkg::HISTORY_DEPTH - 1)) ?
                           count_ff - CW'(twc_pkg::HISTORY_DEPTH - 1) : '0;
                  z_in   = z_eff;
                  l_in   = l_eff;
                  o_in   = reach ? count_ff - CW'(d_eff) : '0;
                  oend_in = count_ff;
                  last_in = is_last;
                  if (is_last) begin
                     count_in = '0;
                     state_in = S_SETUP;
                  end else begin
                     count_in = count_ff + CW'(1);
                     oend_in  = count_ff - CW'(d_eff);
                     if (reach) begin
                        state_in = S_SETUP;
                     end
                  end
               end
            end
         end
         S_SETUP: begin
            ctrl.acc_clear = 1'b1;
            j_in     = $signed({2'b00, o_ff}) + PW'(z_ff);
            k_in     = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            ctrl.rd_en = in_range;
            j_in = j_ff - PW'(1);
            k_in = k_ff + twc_pkg::TAP_AW'(1);
            if ({1'b0, k_ff} == l_ff - RW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!dp_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = dp_result;
               rsp_index_in  = o_ff;
               rsp_last_in   = last_ff && (o_ff == oend_ff);
               if (o_ff == oend_ff) begin
                  state_in = S_IDLE;
               end else begin
                  o_in     = o_ff + CW'(1);
                  state_in = S_SETUP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      lo_ff         <= lo_in;
      o_ff          <= o_in;
      oend_ff       <= oend_in;
      last_ff       <= last_in;
      z_ff          <= z_in;
      l_ff          <= l_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_out_index  = rsp_index_ff;
   assign rsp_out_last   = rsp_last_ff;

   // result taken only once the product pipeline has emptied
   a_out_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> !dp_busy)
      else $error("output written with products in flight");

   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> ({1'b0, k_ff} < l_ff))
      else $error("tap counter past tap count");

   a_trace_end: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == twc_pkg::OP_SAMPLE && req_last_sample)
      |=> (count_ff == '0))
      else $error("sample count not cleared at end of trace");

endmodule

@@ dv/tb_trace_wavelet_convolver_core.sv @@
`timescale 1ns / 100ps

module tb_trace_wavelet_convolver_core;

   localparam int SETTLE      = 2 * (twc_pkg::MAX_TAPS + 5) + 16;
   localparam int IDLE_LIMIT  = 20000;
   localparam int ITEM_TARGET = 130;
   localparam int TAP_SPAN    = 16;

   typedef struct packed {
      logic signed [twc_pkg::SAMPLE_W-1:0] value;
      logic [twc_pkg::COUNT_W-1:0]         position;
      logic                                is_last;
   } conv_out_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_LOAD, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic                                csr_sel;
      logic [twc_pkg::CSR_W-1:0]           csr_val;
      logic [twc_pkg::TAP_AW-1:0]          tap_idx;
      logic signed [twc_pkg::TAP_W-1:0]    tap_val;
      logic signed [twc_pkg::SAMPLE_W-1:0] smp;
      logic                                lst;
      bit                                  typed;
      conv_out_type                        want;
   } stim_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_opcode;
   logic [twc_pkg::TAP_AW-1:0]          req_tap_index;
   logic signed [twc_pkg::TAP_W-1:0]    req_tap_value;
   logic signed [twc_pkg::SAMPLE_W-1:0] req_sample_value;
   logic                                req_last_sample;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [twc_pkg::SAMPLE_W-1:0] rsp_out_sample;
   logic [twc_pkg::COUNT_W-1:0]         rsp_out_index;
   logic                                rsp_out_last;
   logic                                csr_wr_en;
   logic                                csr_addr;
   logic [twc_pkg::CSR_W-1:0]           csr_wdata;

   // predictor state
   logic signed [twc_pkg::TAP_W-1:0]    tap_mem [twc_pkg::MAX_TAPS];
   logic signed [twc_pkg::SAMPLE_W-1:0] hist_mem [twc_pkg::HISTORY_DEPTH];
   int                                  trace_pos;
   logic signed [twc_pkg::CSR_W-1:0]    shift_reg;
   logic [twc_pkg::CSR_W-1:0]           tapcnt_reg;

   conv_out_type pending_outputs [$];
   conv_out_type fresh_outputs [$];
   stim_row_type plan [$];

   int  mismatches;
   int  items_sent;
   int  idle_cycles;
   int  burst_left;
   bit  quiet;
   bit  sender_idle_en;
   bit  stall_en;
   logic [9:0] stall_phase;

   trace_wavelet_convolver_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_tap_index    (req_tap_index),
      .req_tap_value    (req_tap_value),
      .req_sample_value (req_sample_value),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_out_index    (rsp_out_index),
      .rsp_out_last     (rsp_out_last),
      .csr_wr_en        (csr_wr_en),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [twc_pkg::SAMPLE_W-1:0] conv_point(int o, int cur,
                                                                      int z, int l);
      longint acc;
      longint q;
      int     k;
      int     j;
      acc = 0;
      for (k = 0; k < l; k++) begin
         j = o + z - k;
         if (j >= 0 && j <= cur && cur - j < twc_pkg::HISTORY_DEPTH) begin
            acc += longint'(hist_mem[j % twc_pkg::HISTORY_DEPTH]) * longint'(tap_mem[k]);
         end
      end
      q = acc >>> twc_pkg::FRAC_W;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[twc_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic void convolve_item(logic op, logic [twc_pkg::TAP_AW-1:0] ti,
                                         logic signed [twc_pkg::TAP_W-1:0] tv,
                                         logic signed [twc_pkg::SAMPLE_W-1:0] sv,
                                         logic lst);
      int           z;
      int           l;
      int           d;
      int           cur;
      int           first;
      int           o;
      logic         ends;
      conv_out_type r;
      fresh_outputs.delete();
      if (op == twc_pkg::OP_LOAD) begin
         tap_mem[ti] = tv;
         return;
      end
      z = int'(shift_reg);
      if (z > twc_pkg::MAX_DELAY) z = twc_pkg::MAX_DELAY;
      l = int'(tapcnt_reg);
      if (l < 1) l = 1;
      if (l > twc_pkg::MAX_TAPS) l = twc_pkg::MAX_TAPS;
      d = (z > 0) ? z : 0;
      cur = trace_pos;
      hist_mem[cur % twc_pkg::HISTORY_DEPTH] = sv;
      ends = lst || (cur >= twc_pkg::MAX_TRACE - 1);
      if (!ends) begin
         o = cur - d;
         if (o >= 0) begin
            r.value    = conv_point(o, cur, z, l);
            r.position = o[twc_pkg::COUNT_W-1:0];
            r.is_last  = 1'b0;
            fresh_outputs.push_back(r);
         end
         trace_pos = cur + 1;
         return;
      end
      first = (cur - d < 0) ? 0 : cur - d;
      for (o = first; o <= cur; o++) begin
         r.value    = conv_point(o, cur, z, l);
         r.position = o[twc_pkg::COUNT_W-1:0];
         r.is_last  = (o == cur);
         fresh_outputs.push_back(r);
      end
      trace_pos = 0;
   endfunction

   function automatic logic signed [twc_pkg::SAMPLE_W-1:0] rand_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return {{20{r[4]}}, r[3:0]};
         default: return r[twc_pkg::SAMPLE_W-1:0];
      endcase
   endfunction

   function automatic void count_mismatch(string what, conv_out_type want,
                                          conv_out_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s): expected value %0d index %0d last %0b,", what,
                  want.value, want.position, want.is_last);
         $display("   got value %0d index %0d last %0b",
                  got.value, got.position, got.is_last);
      end
   endfunction

   function automatic void add_csr(logic sel, logic [twc_pkg::CSR_W-1:0] val);
      stim_row_type row;
      row = '{kind: ROW_CSR, csr_sel: sel, csr_val: val, tap_idx: '0, tap_val: '0,
              smp: '0, lst: 1'b0, typed: 1'b0, want: '0};
      plan.push_back(row);
   endfunction

   function automatic void add_load(logic [twc_pkg::TAP_AW-1:0] ti,
                                    logic signed [twc_pkg::TAP_W-1:0] tv);
      stim_row_type row;
      row = '{kind: ROW_LOAD, csr_sel: 1'b0, csr_val: '0, tap_idx: ti, tap_val: tv,
              smp: '0, lst: 1'b0, typed: 1'b0, want: '0};
      plan.push_back(row);
   endfunction

   function automatic void add_sample(logic signed [twc_pkg::SAMPLE_W-1:0] sv, logic lst);
      stim_row_type row;
      row = '{kind: ROW_SAMPLE, csr_sel: 1'b0, csr_val: '0, tap_idx: '0, tap_val: '0,
              smp: sv, lst: lst, typed: 1'b0, want: '0};
      plan.push_back(row);
   endfunction

   function automatic void add_sample_chk(logic signed [twc_pkg::SAMPLE_W-1:0] sv,
                                          logic lst,
                                          logic signed [twc_pkg::SAMPLE_W-1:0] ev,
                                          logic [twc_pkg::COUNT_W-1:0] ep, logic el);
      stim_row_type row;
      row = '{kind: ROW_SAMPLE, csr_sel: 1'b0, csr_val: '0, tap_idx: '0, tap_val: '0,
              smp: sv, lst: lst, typed: 1'b1,
              want: '{value: ev, position: ep, is_last: el}};
      plan.push_back(row);
   endfunction

   task automatic wait_quiet();
      if (!quiet) begin
         req_valid <= 1'b0;
         while (pending_outputs.size() != 0) @(posedge clock);
         repeat (SETTLE) @(posedge clock);
         quiet = 1'b1;
      end
   endtask

   task automatic write_csr(logic sel, logic [twc_pkg::CSR_W-1:0] val);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_addr  <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (sel == twc_pkg::CSR_ZERO_SHIFT) shift_reg = val;
      else tapcnt_reg = val;
   endtask

   task automatic drive_req(logic op, logic [twc_pkg::TAP_AW-1:0] ti,
                            logic signed [twc_pkg::TAP_W-1:0] tv,
                            logic signed [twc_pkg::SAMPLE_W-1:0] sv, logic lst,
                            bit typed, conv_out_type want);
      if (sender_idle_en) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_tap_index    <= ti;
      req_tap_value    <= tv;
      req_sample_value <= sv;
      req_last_sample  <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      quiet = 1'b0;
      items_sent++;
      convolve_item(op, ti, tv, sv, lst);
      if (typed) pending_outputs.push_back(want);
      else foreach (fresh_outputs[i]) pending_outputs.push_back(fresh_outputs[i]);
   endtask

   task automatic send_load(logic [twc_pkg::TAP_AW-1:0] ti,
                            logic signed [twc_pkg::TAP_W-1:0] tv);
      drive_req(twc_pkg::OP_LOAD, ti, tv, rand_sample(), 1'($urandom_range(0, 1)),
                1'b0, '0);
   endtask

   task automatic send_sample(logic signed [twc_pkg::SAMPLE_W-1:0] sv, logic lst);
      drive_req(twc_pkg::OP_SAMPLE, 7'($urandom_range(0, 127)), 16'($urandom()), sv, lst,
                1'b0, '0);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      stall_phase <= stall_phase + 10'd1;
      if (!stall_en) rsp_ready <= 1'b1;
      else begin
         case (stall_phase[8:7])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= (stall_phase[2:0] == 3'd0);
            default: rsp_ready <= ($urandom_range(0, 9) > 6);
         endcase
      end
   end

   always @(posedge clock) begin : rsp_check
      conv_out_type got;
      conv_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_sample, rsp_out_index, rsp_out_last};
         if (pending_outputs.size() == 0) count_mismatch("unexpected transaction", '0, got);
         else begin
            want = pending_outputs.pop_front();
            if (got.value !== want.value) count_mismatch("out_sample", want, got);
            else if (got.position !== want.position) count_mismatch("out_index", want, got);
            else if (got.is_last !== want.is_last) count_mismatch("out_last", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int        len;
      bit        open;
      logic [7:0] zs;
      logic [7:0] tc;
      logic [7:0] tmp;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = twc_pkg::OP_LOAD;
      req_tap_index    = '0;
      req_tap_value    = '0;
      req_sample_value = '0;
      req_last_sample  = 1'b0;
      rsp_ready        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_addr         = twc_pkg::CSR_ZERO_SHIFT;
      csr_wdata        = '0;
      stall_phase      = '0;
      mismatches       = 0;
      items_sent       = 0;
      idle_cycles      = 0;
      burst_left       = 0;
      quiet            = 1'b1;
      sender_idle_en   = 1'b1;
      stall_en         = 1'b1;
      trace_pos        = 0;
      shift_reg        = '0;
      tapcnt_reg       = 8'd1;
      foreach (tap_mem[i]) tap_mem[i] = '0;
      foreach (hist_mem[i]) hist_mem[i] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // taps that the random traces can reach, written before any sample reads them
      for (int i = 0; i < TAP_SPAN; i++) send_load(7'(i), 16'($urandom()));

      add_load(7'd0, -16'sd32768);
      add_sample_chk(24'sh7FFFFF, 1'b0, -24'sd8388607, 16'd0, 1'b0);
      add_sample_chk(24'sh800000, 1'b1, 24'sh7FFFFF, 16'd1, 1'b1);
      add_sample_chk(24'sd0, 1'b1, 24'sd0, 16'd0, 1'b1);
      add_load(7'd0, 16'sh4000);
      add_sample_chk(-24'sd1, 1'b0, -24'sd1, 16'd0, 1'b0);
      add_sample_chk(24'sd1, 1'b1, 24'sd0, 16'd1, 1'b1);
      add_csr(twc_pkg::CSR_TAP_COUNT, 8'd0);
      add_sample_chk(24'sd3, 1'b1, 24'sd1, 16'd0, 1'b1);
      add_load(7'd127, 16'sh7FFF);
      // taps reached by the clamped shift on a three-sample trace
      for (int i = twc_pkg::MAX_DELAY - 2; i <= twc_pkg::MAX_DELAY + 2; i++)
         add_load(7'(i), 16'($urandom()));
      add_csr(twc_pkg::CSR_TAP_COUNT, 8'd255);
      add_csr(twc_pkg::CSR_ZERO_SHIFT, 8'd127);
      add_sample(24'sh7FFFFF, 1'b0);
      add_sample(24'sh800000, 1'b0);
      add_sample(24'sd12345, 1'b1);
      add_csr(twc_pkg::CSR_ZERO_SHIFT, 8'h80);
      add_sample(24'sh800000, 1'b0);
      add_sample(24'sh7FFFFF, 1'b1);
      add_csr(twc_pkg::CSR_ZERO_SHIFT, 8'd10);
      add_csr(twc_pkg::CSR_TAP_COUNT, 8'd4);
      add_sample(24'sd1000, 1'b0);
      add_sample(-24'sd2000, 1'b0);
      add_sample(24'sh7FFFFF, 1'b0);
      add_sample(24'sh800000, 1'b1);
      add_csr(twc_pkg::CSR_ZERO_SHIFT, 8'd2);
      add_csr(twc_pkg::CSR_TAP_COUNT, 8'd3);
      add_sample(24'sd100, 1'b0);
      add_sample(-24'sd200, 1'b0);
      // register change in the middle of a trace
      add_csr(twc_pkg::CSR_ZERO_SHIFT, 8'd0);
      add_sample(24'sd300, 1'b0);
      add_sample(-24'sd400, 1'b1);

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_CSR: begin
               write_csr(plan[i].csr_sel, plan[i].csr_val);
            end
            ROW_LOAD: begin
               send_load(plan[i].tap_idx, plan[i].tap_val);
            end
            default: begin
               drive_req(twc_pkg::OP_SAMPLE, 7'($urandom_range(0, 127)), 16'($urandom()),
                         plan[i].smp, plan[i].lst, plan[i].typed, plan[i].want);
            end
         endcase
      end

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0: zs = 8'h80;
            1: zs = 8'd127;
            2: zs = 8'd63;
            3: zs = 8'h81;
            4: zs = 8'($urandom_range(0, 255));
            5: begin
               tmp = 8'($urandom_range(0, 11));
               zs = ~tmp;
            end
            default: zs = 8'($urandom_range(0, 12));
         endcase
         case ($urandom_range(0, 9))
            0: tc = 8'd0;
            1: tc = 8'(TAP_SPAN);
            2: tc = 8'($urandom_range(0, TAP_SPAN));
            default: tc = 8'($urandom_range(1, 12));
         endcase
         write_csr(twc_pkg::CSR_ZERO_SHIFT, zs);
         write_csr(twc_pkg::CSR_TAP_COUNT, tc);
         sender_idle_en = ($urandom_range(0, 3) != 0);
         stall_en       = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(0, 3))
            send_load(7'($urandom_range(0, 127)), 16'($urandom()));
         len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         open = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_load(7'($urandom_range(0, 127)), 16'($urandom()));
            if ($urandom_range(0, 11) == 0) wait_quiet();
            send_sample(rand_sample(), (i == len - 1) && !open);
         end
      end

      wait_quiet();
      if (mismatches == 0 && pending_outputs.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
